[sv/hmm_pkg.sv]
// ----------------------------------------------------------------------------
// hmm_pkg
// Shared types and constants for the histogram matching map core: the
// operation codes, the command word passed from front to back and widths.
// ----------------------------------------------------------------------------
package hmm_pkg;

  localparam int IDX_W     = 8;
  localparam int LVL_W     = 8;
  localparam int Q_DEPTH   = 2;
  localparam int OUT_DEPTH = 2;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_FILL  = 2'd1,
    OP_MAP   = 2'd2,
    OP_CLEAR = 2'd3
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [IDX_W-1:0] idx;
    logic [LVL_W-1:0] val;
  } cmd_t;

endpackage

[sv/hmm_front.sv]
// ----------------------------------------------------------------------------
// hmm_front
// Accepts input transfers, turns each into a command word with one table
// index and one value, and holds the commands in a short queue for the back.
// ----------------------------------------------------------------------------
module hmm_front import hmm_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [1:0]       in_opcode,
  input  logic [IDX_W-1:0] in_ref_equalized_level,
  input  logic [LVL_W-1:0] in_ref_level,
  input  logic [IDX_W-1:0] in_src_equalized_level,
  output logic             q_valid,
  output cmd_t             q_cmd,
  input  logic             q_pop
);

  localparam int QPW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int QCW = $clog2(Q_DEPTH + 1);

  cmd_t           q_mem_r [Q_DEPTH];
  logic [QPW-1:0] wptr_r, wptr_nxt;
  logic [QPW-1:0] rptr_r, rptr_nxt;
  logic [QCW-1:0] cnt_r, cnt_nxt;
  cmd_t           cmd_in;
  logic           push;
  logic           pop;

  always_comb begin
    cmd_in.op = op_t'(in_opcode);
    case (cmd_in.op)
      OP_MAP: begin
        cmd_in.idx = in_src_equalized_level;
        cmd_in.val = '0;
      end
      default: begin
        cmd_in.idx = in_ref_equalized_level;
        cmd_in.val = in_ref_level;
      end
    endcase
  end

  assign in_stall = (cnt_r == QCW'(Q_DEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != '0);
  assign pop      = q_pop && q_valid;
  assign q_cmd    = q_mem_r[rptr_r];

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (push) begin
      wptr_nxt = (wptr_r == QPW'(Q_DEPTH - 1)) ? '0 : wptr_r + QPW'(1);
    end
    if (pop) begin
      rptr_nxt = (rptr_r == QPW'(Q_DEPTH - 1)) ? '0 : rptr_r + QPW'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + QCW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - QCW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wptr_r] <= cmd_in;
    end
  end

endmodule

[sv/hmm_back.sv]
// ----------------------------------------------------------------------------
// hmm_back
// Carries out queued commands on the inverse table: writes for load, reads
// for map, a clear of all entry valid bits at once, and a sequenced walk
// over the table for fill. Map results leave through a two-entry buffer.
// ----------------------------------------------------------------------------
module hmm_back import hmm_pkg::*; #(
  parameter int LEVELS = 256
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_valid,
  input  cmd_t             q_cmd,
  output logic             q_pop,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [LVL_W-1:0] out_matched_level
);

  localparam int DEPTH = (LEVELS < (1 << IDX_W)) ? LEVELS : (1 << IDX_W);
  localparam int AW    = $clog2(DEPTH);
  localparam int OPW   = $clog2(OUT_DEPTH);
  localparam int OCW   = $clog2(OUT_DEPTH + 1);

  typedef enum logic [1:0] {
    ST_RUN  = 2'b01,
    ST_FILL = 2'b10
  } state_t;

  state_t           state_r, state_nxt;
  logic [AW-1:0]    walk_r, walk_nxt;
  logic [LVL_W-1:0] prev_r, prev_nxt;
  logic             pend_r, pend_nxt;
  logic [DEPTH-1:0] vld_r;
  logic [LVL_W-1:0] mem [DEPTH];
  logic [LVL_W-1:0] rd_data_r;
  logic             rd_vld_r;
  logic [LVL_W-1:0] eff;

  logic             rd_en, rd_inr;
  logic [AW-1:0]    rd_addr;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  logic [LVL_W-1:0] wr_data;
  logic             clr;
  logic             idx_inr;

  logic [LVL_W-1:0] ob_r [OUT_DEPTH];
  logic [OPW-1:0]   ob_wp_r, ob_rp_r;
  logic [OCW-1:0]   ob_cnt_r, ob_cnt_nxt;
  logic [OCW:0]     occ;
  logic             deq;
  logic             credit;

  assign eff     = rd_vld_r ? rd_data_r : '0;
  assign idx_inr = (32'(q_cmd.idx) < 32'(DEPTH));

  assign out_valid         = (ob_cnt_r != '0);
  assign out_matched_level = ob_r[ob_rp_r];
  assign deq               = out_valid && !out_stall;
  assign occ               = {1'b0, ob_cnt_r} + (OCW+1)'(pend_r);
  assign credit            = deq ? (occ < (OCW+1)'(OUT_DEPTH + 1))
                                 : (occ < (OCW+1)'(OUT_DEPTH));

  always_comb begin
    q_pop     = 1'b0;
    rd_en     = 1'b0;
    rd_inr    = 1'b0;
    rd_addr   = '0;
    wr_en     = 1'b0;
    wr_addr   = '0;
    wr_data   = '0;
    clr       = 1'b0;
    state_nxt = state_r;
    walk_nxt  = walk_r;
    prev_nxt  = prev_r;
    pend_nxt  = 1'b0;
    case (state_r)
      ST_RUN: begin
        if (q_valid) begin
          case (q_cmd.op)
            OP_LOAD: begin
              q_pop   = 1'b1;
              wr_en   = idx_inr;
              wr_addr = q_cmd.idx[AW-1:0];
              wr_data = q_cmd.val;
            end
            OP_MAP: begin
              if (credit) begin
                q_pop    = 1'b1;
                rd_en    = 1'b1;
                rd_inr   = idx_inr;
                rd_addr  = q_cmd.idx[AW-1:0];
                pend_nxt = 1'b1;
              end
            end
            OP_FILL: begin
              q_pop     = 1'b1;
              rd_en     = 1'b1;
              rd_inr    = 1'b1;
              rd_addr   = '0;
              walk_nxt  = '0;
              state_nxt = ST_FILL;
            end
            OP_CLEAR: begin
              q_pop = 1'b1;
              clr   = 1'b1;
            end
            default: begin
              q_pop = 1'b1;
            end
          endcase
        end
      end
      ST_FILL: begin
        if (walk_r == '0) begin
          prev_nxt = eff;
        end else if (eff == '0) begin
          wr_en   = 1'b1;
          wr_addr = walk_r;
          wr_data = prev_r;
        end else begin
          prev_nxt = eff;
        end
        if (walk_r == AW'(DEPTH - 1)) begin
          state_nxt = ST_RUN;
        end else begin
          walk_nxt = walk_r + AW'(1);
          rd_en    = 1'b1;
          rd_inr   = 1'b1;
          rd_addr  = walk_r + AW'(1);
        end
      end
      default: begin
        state_nxt = ST_RUN;
      end
    endcase
  end

  always_comb begin
    ob_cnt_nxt = ob_cnt_r;
    if (pend_r && !deq) begin
      ob_cnt_nxt = ob_cnt_r + OCW'(1);
    end else if (deq && !pend_r) begin
      ob_cnt_nxt = ob_cnt_r - OCW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_RUN;
      walk_r   <= '0;
      pend_r   <= 1'b0;
      vld_r    <= '0;
      ob_wp_r  <= '0;
      ob_rp_r  <= '0;
      ob_cnt_r <= '0;
    end else begin
      state_r  <= state_nxt;
      walk_r   <= walk_nxt;
      pend_r   <= pend_nxt;
      ob_cnt_r <= ob_cnt_nxt;
      if (clr) begin
        vld_r <= '0;
      end else if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (pend_r) begin
        ob_wp_r <= ob_wp_r + OPW'(1);
      end
      if (deq) begin
        ob_rp_r <= ob_rp_r + OPW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    prev_r <= prev_nxt;
    if (pend_r) begin
      ob_r[ob_wp_r] <= eff;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
      rd_vld_r  <= rd_inr && vld_r[rd_addr];
    end
  end

endmodule

[sv/histogram_matching_map_core.sv]
// ----------------------------------------------------------------------------
// histogram_matching_map_core
// Inverse equalization table for histogram matching: load, fill, map, clear.
// ----------------------------------------------------------------------------
// Load, map and clear items do not hold the back end, so a stream of them
// runs at one item per cycle while results are taken. A map result passes
// through the command queue, the registered table read and the output
// buffer before it is presented on the output. A fill item walks the table
// through its single read port and single write port, one entry per cycle,
// and holds the back end until the walk has reached the last entry. The
// table starts cleared after reset and a clear item empties it at once, by
// clearing the entry valid bits, with no sweep.
// ----------------------------------------------------------------------------
module histogram_matching_map_core import hmm_pkg::*; #(
  parameter int LEVELS = 256
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [1:0]       in_opcode,
  input  logic [IDX_W-1:0] in_ref_equalized_level,
  input  logic [LVL_W-1:0] in_ref_level,
  input  logic [IDX_W-1:0] in_src_equalized_level,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [LVL_W-1:0] out_matched_level
);

  logic q_valid;
  cmd_t q_cmd;
  logic q_pop;

  hmm_front u_front (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_valid               (in_valid),
    .in_stall               (in_stall),
    .in_opcode              (in_opcode),
    .in_ref_equalized_level (in_ref_equalized_level),
    .in_ref_level           (in_ref_level),
    .in_src_equalized_level (in_src_equalized_level),
    .q_valid                (q_valid),
    .q_cmd                  (q_cmd),
    .q_pop                  (q_pop)
  );

  hmm_back #(
    .LEVELS (LEVELS)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_valid           (q_valid),
    .q_cmd             (q_cmd),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_matched_level (out_matched_level)
  );

endmodule

[sv/hmm_chk.sv]
// ----------------------------------------------------------------------------
// hmm_chk
// Port-level checks for the histogram matching map core, bound to the top.
// ----------------------------------------------------------------------------
module hmm_chk import hmm_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_stall,
  input logic             out_valid,
  input logic             out_stall,
  input logic [LVL_W-1:0] out_matched_level
);

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("block not idle after reset");

  a_stall_needs_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(in_stall) |-> $past(in_valid && !in_stall))
    else $error("input stall rose without a transfer");

  a_out_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_out_data_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_matched_level))
    else $error("result changed while stalled");

endmodule

bind histogram_matching_map_core hmm_chk u_hmm_chk (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_matched_level (out_matched_level)
);
